@@ hdl/gpio_ev_pkg.sv @@
// shared types, register offsets and helpers for the gpio controller with event detect
package gpio_ev_pkg;

    localparam int NUM_PINS             = 54;
    localparam int PINS_PER_SELECT_WORD = 10;
    localparam int SEL_WORDS            = 6;
    localparam int SEL_PINS             = SEL_WORDS * PINS_PER_SELECT_WORD;
    localparam int SEL_BITS             = 3 * PINS_PER_SELECT_WORD;

    localparam logic [63:0] PIN_MASK =
        (NUM_PINS >= 64) ? {64{1'b1}} : ((64'd1 << NUM_PINS) - 64'd1);
    localparam logic [31:0] BANK0_MASK = PIN_MASK[31:0];
    localparam logic [31:0] BANK1_MASK = PIN_MASK[63:32];

    // access codes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // function select code that makes a pin an output
    localparam logic [2:0] FSEL_OUTPUT = 3'd1;

    // word offsets of the register map
    localparam logic [5:0] OFF_FSEL_LAST = 6'd5;
    localparam logic [5:0] OFF_SET0      = 6'd7;
    localparam logic [5:0] OFF_SET1      = 6'd8;
    localparam logic [5:0] OFF_CLR0      = 6'd10;
    localparam logic [5:0] OFF_CLR1      = 6'd11;
    localparam logic [5:0] OFF_LEV0      = 6'd13;
    localparam logic [5:0] OFF_LEV1      = 6'd14;
    localparam logic [5:0] OFF_EDS0      = 6'd16;
    localparam logic [5:0] OFF_EDS1      = 6'd17;
    localparam logic [5:0] OFF_REN0      = 6'd19;
    localparam logic [5:0] OFF_REN1      = 6'd20;
    localparam logic [5:0] OFF_FEN0      = 6'd22;
    localparam logic [5:0] OFF_FEN1      = 6'd23;
    localparam logic [5:0] OFF_HEN0      = 6'd25;
    localparam logic [5:0] OFF_HEN1      = 6'd26;
    localparam logic [5:0] OFF_LEN0      = 6'd28;
    localparam logic [5:0] OFF_LEN1      = 6'd29;
    localparam logic [5:0] OFF_AREN0     = 6'd31;
    localparam logic [5:0] OFF_AREN1     = 6'd32;
    localparam logic [5:0] OFF_AFEN0     = 6'd34;
    localparam logic [5:0] OFF_AFEN1     = 6'd35;
    localparam logic [5:0] OFF_PUD       = 6'd37;
    localparam logic [5:0] OFF_PUDCLK0   = 6'd38;
    localparam logic [5:0] OFF_PUDCLK1   = 6'd39;

    typedef enum logic [2:0] {
        EN_RISE,
        EN_FALL,
        EN_HIGH,
        EN_LOW,
        EN_ARISE,
        EN_AFALL
    } t_en_kind;

    typedef struct packed {
        logic [31:0] rise;
        logic [31:0] fall;
        logic [31:0] high;
        logic [31:0] low;
        logic [31:0] arise;
        logic [31:0] afall;
    } t_bank_en;

    typedef struct packed {
        logic     hit;
        logic     bank;
        t_en_kind kind;
    } t_en_sel;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  reg_offset;
        logic [31:0] write_data;
        logic [31:0] pin_level_bank0;
        logic [21:0] pin_level_bank1;
    } t_in_word;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] drive_level_bank0;
        logic [21:0] drive_level_bank1;
        logic [31:0] drive_enable_bank0;
        logic [21:0] drive_enable_bank1;
        logic        irq_bank0;
        logic        irq_bank1;
        logic [1:0]  pull_mode;
        logic [31:0] pull_clock_bank0;
        logic [21:0] pull_clock_bank1;
    } t_out_word;

    // which enable register an offset names, if any
    function automatic t_en_sel en_decode(input logic [5:0] off);
        t_en_sel s;
        s.hit  = 1'b1;
        s.bank = 1'b0;
        s.kind = EN_RISE;
        unique case (off)
            OFF_REN0:  begin s.kind = EN_RISE;  end
            OFF_REN1:  begin s.kind = EN_RISE;  s.bank = 1'b1; end
            OFF_FEN0:  begin s.kind = EN_FALL;  end
            OFF_FEN1:  begin s.kind = EN_FALL;  s.bank = 1'b1; end
            OFF_HEN0:  begin s.kind = EN_HIGH;  end
            OFF_HEN1:  begin s.kind = EN_HIGH;  s.bank = 1'b1; end
            OFF_LEN0:  begin s.kind = EN_LOW;   end
            OFF_LEN1:  begin s.kind = EN_LOW;   s.bank = 1'b1; end
            OFF_AREN0: begin s.kind = EN_ARISE; end
            OFF_AREN1: begin s.kind = EN_ARISE; s.bank = 1'b1; end
            OFF_AFEN0: begin s.kind = EN_AFALL; end
            OFF_AFEN1: begin s.kind = EN_AFALL; s.bank = 1'b1; end
            default:   begin s.hit  = 1'b0; end
        endcase
        return s;
    endfunction

    function automatic logic [31:0] en_get(input t_bank_en en, input t_en_kind kind);
        logic [31:0] v;
        unique case (kind)
            EN_RISE:  v = en.rise;
            EN_FALL:  v = en.fall;
            EN_HIGH:  v = en.high;
            EN_LOW:   v = en.low;
            EN_ARISE: v = en.arise;
            EN_AFALL: v = en.afall;
            default:  v = '0;
        endcase
        return v;
    endfunction

    function automatic t_bank_en en_put(input t_bank_en en, input t_en_kind kind,
                                        input logic [31:0] v);
        t_bank_en r;
        r = en;
        unique case (kind)
            EN_RISE:  r.rise  = v;
            EN_FALL:  r.fall  = v;
            EN_HIGH:  r.high  = v;
            EN_LOW:   r.low   = v;
            EN_ARISE: r.arise = v;
            EN_AFALL: r.afall = v;
            default:  r = en;
        endcase
        return r;
    endfunction

    // bits of a function select word that belong to existing pins
    function automatic logic [SEL_BITS-1:0] sel_mask(input logic [2:0] word);
        logic [SEL_BITS-1:0] m;
        m = '0;
        for (int k = 0; k < PINS_PER_SELECT_WORD; k++) begin
            if ((int'(word) * PINS_PER_SELECT_WORD + k) < NUM_PINS) begin
                m[3*k +: 3] = 3'b111;
            end
        end
        return m;
    endfunction

endpackage

@@ hdl/gpio_ev_detect.sv @@
// per-bank event detector: edges and levels gated by the enable registers
module gpio_ev_detect (
    input  logic [31:0]           i_prev,
    input  logic [31:0]           i_now,
    input  logic [31:0]           i_mask,
    input  gpio_ev_pkg::t_bank_en i_en,
    output logic [31:0]           o_det
);
    import gpio_ev_pkg::*;

    logic [31:0] w_rise;
    logic [31:0] w_fall;

    assign w_rise = ~i_prev & i_now;
    assign w_fall = i_prev & ~i_now;

    // async edges are treated like sampled ones
    assign o_det = ((w_rise & (i_en.rise | i_en.arise))
                 | (w_fall & (i_en.fall | i_en.afall))
                 | (i_now & i_en.high)
                 | (~i_now & i_en.low)) & i_mask;

endmodule

@@ hdl/gpio_controller_with_event_detect.sv @@
// top level of the gpio controller with event detect
// One word in, one word out. Each input word carries one register access
// (none, read or write) and one sample of all pin levels; the block answers
// every input word with exactly one output word holding the read result and
// the pin-facing state (drive latch, drive enables, per-bank interrupts,
// pull controls) as it stands after that word. An accepted word moves from
// the input register to the output register; one word is taken every
// cycle while the output is not stalled, since the whole register update
// and event detection is a single combinational pass between the input
// and output registers. A read sees the registers as they stood before the
// word, except the level registers, which return the word's own sample.
// Detection uses the previous sample and the enables from before the word;
// a newly detected event wins over a write-one-to-clear of the status in
// the same word. Unmapped reads return zero and unmapped writes are dropped.
module gpio_controller_with_event_detect (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  gpio_ev_pkg::t_in_word  i_in_word,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output gpio_ev_pkg::t_out_word o_out_word,
    input  logic                   i_out_stall
);
    import gpio_ev_pkg::*;

    // input register
    logic        r_in_valid;
    t_in_word    r_in;
    // output register
    logic        r_out_valid;
    t_out_word   r_out;

    // controller state
    logic [SEL_BITS-1:0] r_fsel   [SEL_WORDS];
    logic [SEL_BITS-1:0] n_fsel   [SEL_WORDS];
    logic [31:0]         r_latch  [2];
    logic [31:0]         n_latch  [2];
    logic [31:0]         r_status [2];
    logic [31:0]         n_status [2];
    t_bank_en            r_en     [2];
    t_bank_en            n_en     [2];
    logic [31:0]         r_prev   [2];
    logic [1:0]          r_pud;
    logic [1:0]          n_pud;
    logic [31:0]         r_pudclk [2];
    logic [31:0]         n_pudclk [2];

    // handshake
    logic        w_out_free;
    logic        w_move;
    logic        w_in_take;

    // datapath
    logic [31:0] w_now     [2];
    logic [31:0] w_det     [2];
    logic [31:0] w_rd;
    logic [63:0] w_de;
    t_en_sel     w_en_sel;
    logic        w_is_read;
    logic        w_is_write;
    t_out_word   n_out;

    // the output register frees up when empty or being drained; the input
    // register refills in the same cycle it hands its word forward
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_move     = r_in_valid && w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // masked samples: pins that do not exist never store a bit
    assign w_now[0] = r_in.pin_level_bank0 & BANK0_MASK;
    assign w_now[1] = {10'd0, r_in.pin_level_bank1} & BANK1_MASK;

    assign w_is_read  = (r_in.opcode == OP_READ);
    assign w_is_write = (r_in.opcode == OP_WRITE);
    assign w_en_sel   = en_decode(r_in.reg_offset);

    gpio_ev_detect u_det0 (
        .i_prev (r_prev[0]),
        .i_now  (w_now[0]),
        .i_mask (BANK0_MASK),
        .i_en   (r_en[0]),
        .o_det  (w_det[0])
    );

    gpio_ev_detect u_det1 (
        .i_prev (r_prev[1]),
        .i_now  (w_now[1]),
        .i_mask (BANK1_MASK),
        .i_en   (r_en[1]),
        .o_det  (w_det[1])
    );

    // register read, from state before this word
    always_comb begin
        w_rd = '0;
        if (w_is_read) begin
            if (r_in.reg_offset <= OFF_FSEL_LAST) begin
                w_rd = {2'b00, r_fsel[r_in.reg_offset[2:0]]};
            end else if (w_en_sel.hit) begin
                w_rd = en_get(r_en[w_en_sel.bank], w_en_sel.kind);
            end else begin
                case (r_in.reg_offset)
                    OFF_LEV0:    w_rd = w_now[0];
                    OFF_LEV1:    w_rd = w_now[1];
                    OFF_EDS0:    w_rd = r_status[0];
                    OFF_EDS1:    w_rd = r_status[1];
                    OFF_PUD:     w_rd = {30'd0, r_pud};
                    OFF_PUDCLK0: w_rd = r_pudclk[0];
                    OFF_PUDCLK1: w_rd = r_pudclk[1];
                    default:     w_rd = '0;
                endcase
            end
        end
    end

    // register write, then new events on top of any clear
    always_comb begin
        n_fsel   = r_fsel;
        n_latch  = r_latch;
        n_status = r_status;
        n_en     = r_en;
        n_pud    = r_pud;
        n_pudclk = r_pudclk;
        if (w_is_write) begin
            if (r_in.reg_offset <= OFF_FSEL_LAST) begin
                n_fsel[r_in.reg_offset[2:0]] = r_in.write_data[SEL_BITS-1:0]
                                             & sel_mask(r_in.reg_offset[2:0]);
            end else if (w_en_sel.hit) begin
                n_en[w_en_sel.bank] = en_put(r_en[w_en_sel.bank], w_en_sel.kind,
                    r_in.write_data & (w_en_sel.bank ? BANK1_MASK : BANK0_MASK));
            end else begin
                case (r_in.reg_offset)
                    OFF_SET0:    n_latch[0]  = r_latch[0] | (r_in.write_data & BANK0_MASK);
                    OFF_SET1:    n_latch[1]  = r_latch[1] | (r_in.write_data & BANK1_MASK);
                    OFF_CLR0:    n_latch[0]  = r_latch[0] & ~r_in.write_data;
                    OFF_CLR1:    n_latch[1]  = r_latch[1] & ~r_in.write_data;
                    OFF_EDS0:    n_status[0] = r_status[0] & ~r_in.write_data;
                    OFF_EDS1:    n_status[1] = r_status[1] & ~r_in.write_data;
                    OFF_PUD:     n_pud       = r_in.write_data[1:0];
                    OFF_PUDCLK0: n_pudclk[0] = r_in.write_data & BANK0_MASK;
                    OFF_PUDCLK1: n_pudclk[1] = r_in.write_data & BANK1_MASK;
                    default:     n_pud       = r_pud;
                endcase
            end
        end
        n_status[0] = n_status[0] | w_det[0];
        n_status[1] = n_status[1] | w_det[1];
    end

    // drive enables from the updated function select; pins past the select
    // words or past the pin count are never outputs
    for (genvar p = 0; p < 64; p++) begin : g_de
        if (p < SEL_PINS && p < NUM_PINS) begin : g_pin
            assign w_de[p] = (n_fsel[p / PINS_PER_SELECT_WORD]
                              [3 * (p % PINS_PER_SELECT_WORD) +: 3] == FSEL_OUTPUT);
        end else begin : g_none
            assign w_de[p] = 1'b0;
        end
    end

    always_comb begin
        n_out.read_data          = w_rd;
        n_out.drive_level_bank0  = n_latch[0];
        n_out.drive_level_bank1  = n_latch[1][21:0];
        n_out.drive_enable_bank0 = w_de[31:0];
        n_out.drive_enable_bank1 = w_de[53:32];
        n_out.irq_bank0          = |n_status[0];
        n_out.irq_bank1          = |n_status[1];
        n_out.pull_mode          = n_pud;
        n_out.pull_clock_bank0   = n_pudclk[0];
        n_out.pull_clock_bank1   = n_pudclk[1][21:0];
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pud       <= '0;
            for (int i = 0; i < SEL_WORDS; i++) begin
                r_fsel[i] <= '0;
            end
            for (int b = 0; b < 2; b++) begin
                r_latch[b]  <= '0;
                r_status[b] <= '0;
                r_en[b]     <= '0;
                r_prev[b]   <= '0;
                r_pudclk[b] <= '0;
            end
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_move) begin
                r_fsel   <= n_fsel;
                r_latch  <= n_latch;
                r_status <= n_status;
                r_en     <= n_en;
                r_pud    <= n_pud;
                r_pudclk <= n_pudclk;
                r_prev   <= w_now;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_word;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

endmodule
